FILE: rtl/pidt_pkg.sv
// ----------------------------------------------------------------------------
// pidt_pkg: shared types and constants of the altitude PID thrust controller
// Fixed-point scale factors, integral limit and sequencer state encoding.
// ----------------------------------------------------------------------------
package pidt_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_THRUST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRUST_LIMIT = 3'd4;

   localparam logic [CSR_DAT_W-1:0] THRUST_LIMIT_RST = 16'hFFFF;

   // integral limit: 100 cm*s in units of 1/16 cm * ms
   localparam logic signed [24:0] ITG_LIMIT = 25'sd1600000;

   // multiplier B-side scale constants
   localparam logic signed [24:0] E_SCALE = 25'sd1000;
   localparam logic signed [24:0] I_DEN   = 25'sd4096000;
   localparam logic signed [24:0] D_SCALE = 25'sd1000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDT,
      ST_INT,
      ST_P,
      ST_I,
      ST_B,
      ST_T,
      ST_N,
      ST_L,
      ST_DV,
      ST_DD,
      ST_DM,
      ST_DA,
      ST_CHK,
      ST_DIV,
      ST_DONE
   } pidt_state_type;

endpackage

FILE: rtl/pid_thrust_controller.sv
// ----------------------------------------------------------------------------
// pid_thrust_controller: altitude PID with integral clamp
// Sequence: a compute request runs the multiplier states, a range check and,
// unless the thrust saturates, the divider; a clear request gives no response.
// One request at a time, held off until the last response is loaded; a single
// shared 42x25 multiplier stepped 11 times and a 16-step restoring divider.
// Reset (synchronous, active high): gains and base zero, limit 65535, history
// cleared; no clearing pass.
// ----------------------------------------------------------------------------
module pid_thrust_controller
   import pidt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic signed [13:0]   req_height_error,
   input  logic [9:0]           req_elapsed_ms,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_thrust,
   output logic                 rsp_saturated,
   output logic                 rsp_integral_clamped,
   // configuration port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   pidt_state_type state_ff, state_in;

   // configuration
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, base_ff, limit_ff;

   // history
   logic signed [21:0] integ_ff, integ_in;
   logic signed [13:0] prev_ff;

   // working registers
   logic signed [13:0] e_ff;
   logic [9:0]         dt_ff, den_ff;
   logic signed [14:0] diff_ff;
   logic signed [63:0] prod_ff;
   logic signed [41:0] acc_ff;
   logic signed [41:0] tmp_ff;
   logic signed [63:0] num_ff;
   logic signed [63:0] lim_ff;
   logic [31:0]        div_ff;
   logic [47:0]        rem_ff;
   logic [47:0]        dsh_ff;
   logic [3:0]         cnt_ff;
   logic [15:0]        thr_ff;
   logic               sat_ff;
   logic               iclamp_ff, iclamp_in;

   // output register
   logic               rsp_valid_ff;
   logic [15:0]        rsp_thrust_ff;
   logic               rsp_sat_ff;
   logic               rsp_iclamp_ff;

   // shared multiplier
   logic signed [41:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [66:0] mul_p;

   logic signed [24:0] isum;
   logic               div_ge;
   logic [15:0]        quo_in;
   logic               req_take;
   logic               rsp_load;

   assign mul_p    = mul_a * mul_b;
   assign req_take = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign isum = 25'(integ_ff) + $signed(prod_ff[24:0]);
   assign div_ge = rem_ff >= dsh_ff;
   assign quo_in = {thr_ff[14:0], div_ge};

   always_comb begin
      integ_in  = integ_ff;
      iclamp_in = 1'b0;
      if (isum > ITG_LIMIT) begin
         integ_in  = 22'(ITG_LIMIT);
         iclamp_in = 1'b1;
      end else if (isum < -ITG_LIMIT) begin
         integ_in  = 22'(-ITG_LIMIT);
         iclamp_in = 1'b1;
      end else begin
         integ_in  = 22'(isum);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && !req_action) state_in = ST_EDT;
         end
         ST_EDT:  state_in = ST_INT;
         ST_INT:  state_in = ST_P;
         ST_P:    state_in = ST_I;
         ST_I:    state_in = ST_B;
         ST_B:    state_in = ST_T;
         ST_T:    state_in = ST_N;
         ST_N:    state_in = ST_L;
         ST_L:    state_in = ST_DV;
         ST_DV:   state_in = ST_DD;
         ST_DD:   state_in = ST_DM;
         ST_DM:   state_in = ST_DA;
         ST_DA:   state_in = ST_CHK;
         ST_CHK: begin
            if (num_ff < 0 || num_ff > lim_ff) state_in = ST_DONE;
            else                               state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == 4'd0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and multiplier operand select
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_EDT: begin
            mul_a = 42'(e_ff);
            mul_b = $signed({15'd0, dt_ff});
         end
         ST_INT: begin
            mul_a = 42'(e_ff);
            mul_b = E_SCALE;
         end
         ST_P: begin
            mul_a = $signed(prod_ff[41:0]);
            mul_b = $signed({9'd0, gain_p_ff});
         end
         ST_I: begin
            mul_a = 42'(integ_ff);
            mul_b = $signed({9'd0, gain_i_ff});
         end
         ST_B: begin
            mul_a = $signed({26'd0, base_ff});
            mul_b = I_DEN;
         end
         ST_T: begin
            mul_a = $signed({26'd0, limit_ff});
            mul_b = I_DEN;
         end
         ST_N: begin
            mul_a = acc_ff;
            mul_b = $signed({15'd0, den_ff});
         end
         ST_L: begin
            mul_a = tmp_ff;
            mul_b = $signed({15'd0, den_ff});
         end
         ST_DV: begin
            mul_a = $signed({32'd0, den_ff});
            mul_b = I_DEN;
         end
         ST_DD: begin
            mul_a = 42'(diff_ff);
            mul_b = $signed({9'd0, gain_d_ff});
         end
         ST_DM: begin
            mul_a = $signed(prod_ff[41:0]);
            mul_b = D_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         base_ff      <= '0;
         limit_ff     <= THRUST_LIMIT_RST;
         integ_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_P:       gain_p_ff <= csr_wdata;
               CSR_GAIN_I:       gain_i_ff <= csr_wdata;
               CSR_GAIN_D:       gain_d_ff <= csr_wdata;
               CSR_BASE_THRUST:  base_ff   <= csr_wdata;
               CSR_THRUST_LIMIT: limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_take && req_action) begin
            integ_ff <= '0;
            prev_ff  <= '0;
         end
         if (state_ff == ST_INT) begin
            integ_ff <= integ_in;
            prev_ff  <= e_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff != ST_IDLE && state_ff != ST_CHK && state_ff != ST_DIV &&
          state_ff != ST_DONE && state_ff != ST_DA) begin
         prod_ff <= mul_p[63:0];
      end
      case (state_ff)
         ST_IDLE: begin
            e_ff   <= req_height_error;
            dt_ff  <= req_elapsed_ms;
            den_ff <= (req_elapsed_ms == 10'd0) ? 10'd1 : req_elapsed_ms;
         end
         ST_INT: begin
            iclamp_ff <= iclamp_in;
            diff_ff   <= 15'(e_ff) - 15'(prev_ff);
         end
         ST_I:  acc_ff <= $signed(prod_ff[41:0]);
         ST_B:  acc_ff <= acc_ff + $signed(prod_ff[41:0]);
         ST_T:  acc_ff <= acc_ff + $signed(prod_ff[41:0]);
         ST_N:  tmp_ff <= $signed(prod_ff[41:0]);
         ST_L:  num_ff <= prod_ff;
         ST_DV: lim_ff <= prod_ff;
         ST_DD: div_ff <= prod_ff[31:0];
         ST_DA: begin
            // derivative only counts when time has passed
            if (dt_ff != 10'd0) num_ff <= num_ff + prod_ff;
         end
         ST_CHK: begin
            sat_ff <= 1'b0;
            cnt_ff <= 4'd15;
            rem_ff <= num_ff[47:0];
            dsh_ff <= {1'b0, div_ff, 15'd0};
            thr_ff <= '0;
            if (num_ff < 0) begin
               sat_ff <= 1'b1;
            end else if (num_ff > lim_ff) begin
               thr_ff <= limit_ff;
               sat_ff <= 1'b1;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, divisor walks right
            if (div_ge) rem_ff <= rem_ff - dsh_ff;
            dsh_ff <= {1'b0, dsh_ff[47:1]};
            thr_ff <= quo_in;
            cnt_ff <= cnt_ff - 4'd1;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_thrust_ff <= thr_ff;
               rsp_sat_ff    <= sat_ff;
               rsp_iclamp_ff <= iclamp_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_thrust           = rsp_thrust_ff;
   assign rsp_saturated        = rsp_sat_ff;
   assign rsp_integral_clamped = rsp_iclamp_ff;

   // integral stays inside its clamp
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= 22'(ITG_LIMIT)) && (integ_ff >= 22'(-ITG_LIMIT)))
      else $error("integral outside clamp");

   // a compute request keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_action) |=> !req_ready)
      else $error("ready while computing");

   // restoring divider: remainder below twice the shifted divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < {dsh_ff, 1'b0}))
      else $error("divider remainder out of range");

endmodule

FILE: tb/sv/tb_pid_thrust_controller.sv
// ----------------------------------------------------------------------------
// tb_pid_thrust_controller: self-checking bench for the altitude PID
// A table of directed requests runs first: reset state, integral clamp at and
// beyond its limit, zero elapsed time, thrust at zero and at the limit, clears.
// Randomized requests follow under several gain and limit settings. Each
// response is compared with its tabled value or an in-bench thrust predictor
// that uses exact 64-bit arithmetic. Both sides of the channel stall at random.
// ----------------------------------------------------------------------------
module tb_pid_thrust_controller
   import pidt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ACT_COMPUTE = 1'b0;
   localparam logic ACT_CLEAR   = 1'b1;

   localparam longint INTEGRAL_MAX = 64'sd1600000;
   localparam longint THRUST_DEN   = 64'sd4096000;
   localparam longint ERR_SCALE    = 64'sd1000;
   localparam longint RATE_SCALE   = 64'sd1000000;

   localparam int IDLE_PCT       = 17;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_REQUESTS = 90;

   typedef struct packed {
      logic [15:0] thrust;
      logic        saturated;
      logic        integral_clamped;
   } thrust_result_type;

   typedef struct {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] data;
      logic                 act;
      logic signed [13:0]   err;
      logic [9:0]           ms;
      logic                 typed;
      thrust_result_type    want;
   } step_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = ACT_COMPUTE;
   logic signed [13:0]   req_height_error = '0;
   logic [9:0]           req_elapsed_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [15:0]          rsp_thrust;
   logic                 rsp_saturated;
   logic                 rsp_integral_clamped;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the loop history
   logic [15:0] cfg_gain_p = '0;
   logic [15:0] cfg_gain_i = '0;
   logic [15:0] cfg_gain_d = '0;
   logic [15:0] cfg_base   = '0;
   logic [15:0] cfg_limit  = THRUST_LIMIT_RST;
   longint      integral_acc = 0;
   longint      last_error   = 0;

   thrust_result_type thrust_expect_q[$];
   step_row_type      dir_rows[$];

   int fail_count   = 0;
   int sent_count   = 0;
   int clear_count  = 0;
   int rsp_count    = 0;
   int csr_count    = 0;
   bit no_idle      = 1'b0;
   int hold_asks    = 0;

   pid_thrust_controller dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_height_error     (req_height_error),
      .req_elapsed_ms       (req_elapsed_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_thrust           (rsp_thrust),
      .rsp_saturated        (rsp_saturated),
      .rsp_integral_clamped (rsp_integral_clamped),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_pid_thrust_controller: FAIL");
      $finish;
   end

   // Advance the integral and error history for one compute request and work
   // out its thrust over the common denominator, with no intermediate rounding.
   function automatic thrust_result_type thrust_predict(input logic signed [13:0] err,
                                                        input logic [9:0] ms);
      thrust_result_type r;
      longint e, dt, sum, diff, den, num, lim;
      e = err;
      dt = longint'(ms);
      r = '0;
      sum = integral_acc + e * dt;
      if (sum > INTEGRAL_MAX) begin
         sum = INTEGRAL_MAX;
         r.integral_clamped = 1'b1;
      end else if (sum < -INTEGRAL_MAX) begin
         sum = -INTEGRAL_MAX;
         r.integral_clamped = 1'b1;
      end
      integral_acc = sum;
      diff = e - last_error;
      last_error = e;
      den = (dt == 0) ? 64'sd1 : dt;
      num = longint'(cfg_base) * THRUST_DEN * den
          + longint'(cfg_gain_p) * e * ERR_SCALE * den
          + longint'(cfg_gain_i) * integral_acc * den;
      if (dt != 0)
         num += longint'(cfg_gain_d) * diff * RATE_SCALE;
      den = den * THRUST_DEN;
      lim = longint'(cfg_limit) * den;
      if (num < 0) begin
         r.thrust = '0;
         r.saturated = 1'b1;
      end else if (num > lim) begin
         r.thrust = cfg_limit;
         r.saturated = 1'b1;
      end else begin
         r.thrust = 16'(num / den);
      end
      return r;
   endfunction

   function automatic void add_req(input logic act, input int err, input int ms);
      step_row_type row;
      row = '{default: '0};
      row.act = act;
      row.err = 14'(err);
      row.ms = 10'(ms);
      dir_rows.push_back(row);
   endfunction

   function automatic void add_known(input int err, input int ms, input int thrust,
                                     input logic sat, input logic iclamp);
      step_row_type row;
      row = '{default: '0};
      row.act = ACT_COMPUTE;
      row.err = 14'(err);
      row.ms = 10'(ms);
      row.typed = 1'b1;
      row.want = '{16'(thrust), sat, iclamp};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx, input int data);
      step_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = 16'(data);
      dir_rows.push_back(row);
   endfunction

   // Offer one request and hold it until taken; valid stays high afterwards so
   // that back-to-back requests need no second assignment in the same step.
   task automatic push_request(input logic act, input logic signed [13:0] err,
                               input logic [9:0] ms, input logic typed,
                               input thrust_result_type want);
      thrust_result_type r;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_height_error <= err;
      req_elapsed_ms <= ms;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (act == ACT_CLEAR) begin
         integral_acc = 0;
         last_error = 0;
         clear_count++;
      end else begin
         r = thrust_predict(err, ms);
         thrust_expect_q.push_back(typed ? want : r);
      end
   endtask

   // Drop valid, wait for every outstanding response, then let a clear finish.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (thrust_expect_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      csr_count++;
      case (idx)
         CSR_GAIN_P:       cfg_gain_p = val;
         CSR_GAIN_I:       cfg_gain_i = val;
         CSR_GAIN_D:       cfg_gain_d = val;
         CSR_BASE_THRUST:  cfg_base = val;
         CSR_THRUST_LIMIT: cfg_limit = val;
         default: ;
      endcase
   endtask

   // response side: check, then pick next ready
   initial begin
      thrust_result_type exp_r;
      int hold_done;
      int hold_left;
      hold_done = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            rsp_count++;
            if (thrust_expect_q.size() == 0) begin
               $error("unexpected response: thrust %0d saturated %0b clamped %0b",
                      rsp_thrust, rsp_saturated, rsp_integral_clamped);
               fail_count++;
            end else begin
               exp_r = thrust_expect_q.pop_front();
               if (rsp_thrust !== exp_r.thrust) begin
                  $error("thrust: expected %0d, actual %0d", exp_r.thrust, rsp_thrust);
                  fail_count++;
               end
               if (rsp_saturated !== exp_r.saturated) begin
                  $error("saturated: expected %0b, actual %0b",
                         exp_r.saturated, rsp_saturated);
                  fail_count++;
               end
               if (rsp_integral_clamped !== exp_r.integral_clamped) begin
                  $error("integral_clamped: expected %0b, actual %0b",
                         exp_r.integral_clamped, rsp_integral_clamped);
                  fail_count++;
               end
            end
         end
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      step_row_type       row;
      logic               act;
      logic signed [13:0] err;
      logic [9:0]         ms;
      int                 walk;

      // reset state: all gains zero, so thrust stays at zero
      add_known(100, 10, 0, 1'b0, 1'b0);
      add_known(6400, 1000, 0, 1'b0, 1'b1);
      add_known(-6400, 1000, 0, 1'b0, 1'b1);
      add_req(ACT_CLEAR, 0, 0);
      add_known(8191, 0, 0, 1'b0, 1'b0);
      add_csr(CSR_BASE_THRUST, 1000);
      add_csr(CSR_THRUST_LIMIT, 2000);
      add_known(0, 0, 1000, 1'b0, 1'b0);
      add_csr(CSR_GAIN_P, 65535);
      add_known(6400, 1, 2000, 1'b1, 1'b0);
      add_known(-8192, 1, 0, 1'b1, 1'b0);
      // thrust landing exactly on the limit is not saturated
      add_csr(CSR_GAIN_P, 0);
      add_csr(CSR_THRUST_LIMIT, 1000);
      add_known(0, 0, 1000, 1'b0, 1'b0);
      add_csr(CSR_GAIN_P, 256);
      add_csr(CSR_GAIN_I, 300);
      add_csr(CSR_GAIN_D, 500);
      add_csr(CSR_BASE_THRUST, 30000);
      add_csr(CSR_THRUST_LIMIT, 65535);
      // indexes past the register list must be ignored
      add_csr(CSR_THRUST_LIMIT + 3'd1, 65535);
      add_csr(CSR_THRUST_LIMIT + 3'd2, 0);
      add_csr(CSR_THRUST_LIMIT + 3'd3, 12345);
      add_req(ACT_CLEAR, 0, 0);
      add_req(ACT_COMPUTE, 16, 20);
      add_req(ACT_COMPUTE, -16, 0);
      add_req(ACT_COMPUTE, 0, 1023);
      add_req(ACT_COMPUTE, -6400, 1000);
      add_req(ACT_COMPUTE, 6400, 1000);
      // integral sitting exactly on each limit, then just past it
      add_req(ACT_CLEAR, 0, 0);
      add_req(ACT_COMPUTE, 1600, 1000);
      add_req(ACT_COMPUTE, 0, 5);
      add_req(ACT_COMPUTE, 1, 1);
      add_req(ACT_CLEAR, 0, 0);
      add_req(ACT_COMPUTE, -1600, 1000);
      add_req(ACT_COMPUTE, -1, 1);
      add_req(ACT_COMPUTE, -8192, 1023);
      add_req(ACT_COMPUTE, 8191, 1023);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            settle();
            write_csr(row.idx, row.data);
         end else begin
            push_request(row.act, row.err, row.ms, row.typed, row.want);
         end
      end

      walk = 0;
      for (int phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: begin
               write_csr(CSR_GAIN_P, 16'($urandom_range(512, 64)));
               write_csr(CSR_GAIN_I, 16'($urandom_range(256)));
               write_csr(CSR_GAIN_D, 16'($urandom_range(512)));
               write_csr(CSR_BASE_THRUST, 16'($urandom_range(40000, 20000)));
               write_csr(CSR_THRUST_LIMIT, 16'($urandom_range(65535, 50000)));
            end
            1: begin
               write_csr(CSR_GAIN_P, 16'hFFFF);
               write_csr(CSR_GAIN_I, 16'hFFFF);
               write_csr(CSR_GAIN_D, 16'hFFFF);
               write_csr(CSR_BASE_THRUST, 16'hFFFF);
               write_csr(CSR_THRUST_LIMIT, 16'hFFFF);
            end
            2: begin
               write_csr(CSR_GAIN_P, 16'($urandom));
               write_csr(CSR_GAIN_I, 16'($urandom));
               write_csr(CSR_GAIN_D, 16'($urandom));
               write_csr(CSR_BASE_THRUST, 16'($urandom));
               write_csr(CSR_THRUST_LIMIT, 16'h0000);
            end
            3: begin
               write_csr(CSR_GAIN_P, 16'h0000);
               write_csr(CSR_GAIN_I, 16'h0000);
               write_csr(CSR_GAIN_D, 16'h0000);
               write_csr(CSR_BASE_THRUST, 16'($urandom));
               write_csr(CSR_THRUST_LIMIT, 16'($urandom));
            end
            default: begin
               write_csr(CSR_GAIN_P, 16'($urandom_range(1024)));
               write_csr(CSR_GAIN_I, 16'($urandom_range(1024)));
               write_csr(CSR_GAIN_D, 16'($urandom_range(1024)));
               write_csr(CSR_BASE_THRUST, 16'($urandom_range(65535)));
               write_csr(CSR_THRUST_LIMIT, 16'($urandom_range(65535, 1000)));
            end
         endcase
         write_csr(CSR_THRUST_LIMIT + 3'd1 + 3'($urandom_range(2)), 16'($urandom));
         no_idle = (phase == 3);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // stall the response side long enough to back up the request side
            if (phase == 1 && n == 20)
               hold_asks++;
            act = ($urandom_range(19) == 0) ? ACT_CLEAR : ACT_COMPUTE;
            case ($urandom_range(9))
               0: err = 14'($urandom);
               1: err = $urandom_range(1) ? 14'sd6400 : -14'sd6400;
               2: begin
                  walk = int'($urandom_range(12800)) - 6400;
                  err = 14'(walk);
               end
               default: begin
                  // drift like a real altitude loop
                  walk = walk + int'($urandom_range(400)) - 200;
                  if (walk > 6400) walk = 6400;
                  if (walk < -6400) walk = -6400;
                  err = 14'(walk);
               end
            endcase
            case ($urandom_range(7))
               0: ms = '0;
               1: ms = 10'($urandom);
               2: ms = 10'($urandom_range(1000, 400));
               default: ms = 10'($urandom_range(40, 1));
            endcase
            push_request(act, err, ms, 1'b0, '0);
         end
         no_idle = 1'b0;
      end

      settle();
      $display("run covered %0d requests (%0d clears) over 5 random settings",
               sent_count, clear_count);
      $display("%0d responses checked, %0d register writes, %0d mismatches",
               rsp_count, csr_count, fail_count);
      if (fail_count == 0)
         $display("tb_pid_thrust_controller: PASS");
      else
         $display("tb_pid_thrust_controller: FAIL");
      $finish;
   end

endmodule
